>>> rtl/core/rhc_pkg.sv
// Shared types, character codes and match tables for the registration checker
`default_nettype none

package rhc_pkg;

  // one input item as it travels through the block
  typedef struct packed {
    logic       end_of_message;
    logic [7:0] data_byte;
  } rhc_item_t;

  // checker state carried from byte to byte
  typedef struct packed {
    logic [2:0] line_number;
    logic [3:0] match_position;
    logic [2:0] user_field_step;
    logic       body_seen;
    logic       prev_was_cr;
    logic       failed;
    logic       complete;
  } rhc_state_t;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // line numbers
  localparam logic [2:0] LINE_GREETING = 3'd0;
  localparam logic [2:0] LINE_USER     = 3'd3;
  localparam logic [2:0] LINE_DONE     = 3'd4;

  // steps within the user line
  localparam logic [2:0] USER_COLON = 3'd3;
  localparam logic [2:0] USER_BODY  = 3'd4;

  // positions within a line
  localparam logic [3:0] GREETING_LAST = 4'd7;
  localparam logic [3:0] PREFIX_LEN    = 4'd5;
  localparam logic [3:0] BODY_SAT      = 4'd7;

  // "CAP LS" CR LF
  localparam logic [7:0] GREETING [8] = '{
    8'h43, 8'h41, 8'h50, 8'h20, 8'h4C, 8'h53, 8'h0D, 8'h0A
  };

  // command prefixes: 0 = "PASS ", 1 = "NICK ", 2 = "USER "
  function automatic logic [7:0] prefix_byte(input logic [1:0] sel, input logic [2:0] pos);
    logic [39:0] word;
    begin
      unique case (sel)
        2'd0:    word = {8'h20, 8'h53, 8'h53, 8'h41, 8'h50};
        2'd1:    word = {8'h20, 8'h4B, 8'h43, 8'h49, 8'h4E};
        2'd2:    word = {8'h20, 8'h52, 8'h45, 8'h53, 8'h55};
        default: word = '0;
      endcase
      unique case (pos)
        3'd0:    prefix_byte = word[7:0];
        3'd1:    prefix_byte = word[15:8];
        3'd2:    prefix_byte = word[23:16];
        3'd3:    prefix_byte = word[31:24];
        3'd4:    prefix_byte = word[39:32];
        default: prefix_byte = 8'h00;
      endcase
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/rhc_in_reg.sv
// Input register stage that holds one accepted item until the checker consumes it
`default_nettype none

module rhc_in_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire rhc_pkg::rhc_item_t in_item_i,
  output logic                  valid_o,
  output rhc_pkg::rhc_item_t    item_o,
  input  wire logic             pop_i
);

  logic               valid_q;
  rhc_pkg::rhc_item_t item_q;

  // take a new item when empty or when the held one leaves this cycle
  assign in_ready_o = !valid_q || pop_i;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

>>> rtl/core/rhc_core.sv
// Per-byte checker state and its next-state logic
`default_nettype none

module rhc_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire rhc_pkg::rhc_item_t item_i,
  input  wire logic               out_free_i,
  output logic                    pop_o,
  output logic                    result_valid_o,
  output logic                    accepted_o
);

  rhc_pkg::rhc_state_t state_q;
  rhc_pkg::rhc_state_t state_d;
  rhc_pkg::rhc_state_t step;
  logic                last;

  assign last = item_i.end_of_message;

  // a final byte needs room in the output register, other bytes never stall
  assign pop_o          = valid_i && (!last || out_free_i);
  assign result_valid_o = pop_o && last;
  assign accepted_o     = step.complete && !step.failed;

  // effect of one byte on the state
  always_comb begin
    logic       cr_before;
    logic [7:0] b;
    logic [1:0] pfx_sel;
    cr_before = state_q.prev_was_cr;
    b         = item_i.data_byte;
    pfx_sel   = 2'(state_q.line_number - 3'd1);
    step      = state_q;
    if (!(state_q.failed || state_q.complete)) begin
      step.prev_was_cr = (b == rhc_pkg::CH_CR);
      if (state_q.line_number == rhc_pkg::LINE_GREETING) begin
        // greeting line matched literally
        if (b != rhc_pkg::GREETING[state_q.match_position[2:0]]) begin
          step.failed = 1'b1;
        end else if (state_q.match_position >= rhc_pkg::GREETING_LAST) begin
          step.line_number    = 3'd1;
          step.match_position = '0;
          step.prev_was_cr    = 1'b0;
        end else begin
          step.match_position = state_q.match_position + 4'd1;
        end
      end else if (state_q.line_number > rhc_pkg::LINE_USER) begin
        step.failed = 1'b1;
      end else if (state_q.match_position < rhc_pkg::PREFIX_LEN) begin
        // command prefix
        if (b != rhc_pkg::prefix_byte(pfx_sel, state_q.match_position[2:0])) begin
          step.failed = 1'b1;
        end else begin
          step.match_position = state_q.match_position + 4'd1;
        end
      end else if (state_q.line_number == rhc_pkg::LINE_USER &&
                   state_q.user_field_step < rhc_pkg::USER_BODY) begin
        // user line fields and the colon
        if (state_q.user_field_step == rhc_pkg::USER_COLON) begin
          if (b != rhc_pkg::CH_COLON) begin
            step.failed = 1'b1;
          end else begin
            step.user_field_step = rhc_pkg::USER_BODY;
            step.match_position  = rhc_pkg::PREFIX_LEN;
            step.prev_was_cr     = 1'b0;
          end
        end else if (b == rhc_pkg::CH_NUL) begin
          step.failed = 1'b1;
        end else if (b == rhc_pkg::CH_SP) begin
          if (!state_q.body_seen) begin
            step.failed = 1'b1;
          end else begin
            step.user_field_step = state_q.user_field_step + 3'd1;
            step.body_seen       = 1'b0;
          end
        end else if (b == rhc_pkg::CH_LF && cr_before) begin
          step.failed = 1'b1;
        end else begin
          step.body_seen = 1'b1;
        end
      end else begin
        // body of a command line
        if (b == rhc_pkg::CH_LF) begin
          if (cr_before && state_q.match_position >= rhc_pkg::BODY_SAT) begin
            if (state_q.line_number == rhc_pkg::LINE_USER) begin
              step.complete    = 1'b1;
              step.line_number = rhc_pkg::LINE_DONE;
            end else begin
              step.line_number = state_q.line_number + 3'd1;
            end
            step.match_position = '0;
            step.prev_was_cr    = 1'b0;
          end else begin
            step.failed = 1'b1;
          end
        end else if (b == rhc_pkg::CH_NUL) begin
          step.failed = 1'b1;
        end else if (state_q.match_position < rhc_pkg::BODY_SAT) begin
          step.match_position = state_q.match_position + 4'd1;
        end
      end
    end
  end

  // commit the step, clear after the final byte
  always_comb begin
    state_d = state_q;
    if (pop_o) begin
      state_d = last ? '0 : step;
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  // failure stays until the message ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.failed && !(pop_o && last) |=> state_q.failed)
    else $error("failure flag dropped inside a message");

  // state is clear after a final byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && last |=> state_q == '0)
    else $error("state not cleared after final byte");

  // completion only with all four lines done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.complete |-> state_q.line_number == rhc_pkg::LINE_DONE)
    else $error("complete set before line four ended");

  // a result is only produced when the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> out_free_i)
    else $error("result produced while output register full");

endmodule

`default_nettype wire

>>> rtl/core/rhc_out_reg.sv
// Output register that holds one verdict until the receiver takes it
`default_nettype none

module rhc_out_reg (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  wire logic accepted_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic      accepted_o
);

  logic valid_q;
  logic accepted_q;

  // room when empty or when the held verdict leaves this cycle
  assign free_o = !valid_q || out_ready_i;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      accepted_q <= accepted_i;
    end
  end

  assign out_valid_o = valid_q;
  assign accepted_o  = accepted_q;

endmodule

`default_nettype wire

>>> rtl/core/registration_handshake_checker.sv
// Top level of the registration handshake checker
//
// Checks a chat-server registration message byte by byte: a greeting line,
// a password line, a nickname line and a user line, each closed by CR LF.
// Bytes arrive on the s_axis channel, one per item, with tlast on the final
// byte of the message. Exactly one verdict leaves on the m_axis channel per
// message, on the item after the final byte: bit 0 of tdata is 1 when the
// whole handshake was well formed.
// Throughput is one byte per clock while no final byte waits for the output
// register. A byte is held in the input register and the checker state is
// updated from it as it leaves; the verdict is then registered for m_axis.
// While a verdict waits in the output register, ordinary bytes of the next
// message still flow; only the next final byte waits for the register to
// empty, which then backs up s_axis_tready.
// Reset clears the checker state and both handshake registers; no verdict is
// produced during it. After each final byte the checker returns to its reset
// state by itself.
`default_nettype none

module registration_handshake_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  wire logic       s_axis_tlast,   // end_of_message
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata    // [0] accepted, [7:1] zero
);

  rhc_pkg::rhc_item_t in_item;
  rhc_pkg::rhc_item_t held_item;
  logic               held_valid;
  logic               pop;
  logic               out_free;
  logic               result_valid;
  logic               result_accepted;
  logic               out_accepted;

  assign in_item.data_byte      = s_axis_tdata;
  assign in_item.end_of_message = s_axis_tlast;

  // input register
  rhc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .valid_o    (held_valid),
    .item_o     (held_item),
    .pop_i      (pop)
  );

  // checker state
  rhc_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (held_valid),
    .item_i         (held_item),
    .out_free_i     (out_free),
    .pop_o          (pop),
    .result_valid_o (result_valid),
    .accepted_o     (result_accepted)
  );

  // verdict register
  rhc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (result_valid),
    .accepted_i  (result_accepted),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .accepted_o  (out_accepted)
  );

  assign m_axis_tdata = {7'd0, out_accepted};

endmodule

`default_nettype wire

>>> dv/rhc_verdict_checker.sv
// Verdict checker for the registration handshake checker: parser mirror and scoreboard
`default_nettype none

module rhc_verdict_checker
  import rhc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  input  wire logic       s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  wire logic       s_axis_tlast,   // end_of_message
  input  wire logic       m_axis_tvalid,
  input  wire logic       m_axis_tready,
  input  wire logic [7:0] m_axis_tdata,   // [0] accepted, [7:1] zero
  output int              fail_count_o,
  output int              pending_o,
  output int              bytes_o,
  output int              messages_o,
  output int              accepted_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // line numbers between the greeting and the user line
  localparam logic [2:0] LINE_PASS = 3'd1;
  localparam logic [2:0] LINE_NICK = 3'd2;

  rhc_state_t parse_state = '0;
  rhc_state_t next_state;
  logic       verdict_exp;
  logic       pending_verdicts [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    bytes_o      = 0;
    messages_o   = 0;
    accepted_o   = 0;
  end

  // command word expected at the head of lines two to four
  function automatic logic [7:0] command_char(input logic [2:0] line, input logic [3:0] pos);
    logic [39:0] text;
    case (line)
      LINE_PASS: text = "PASS ";
      LINE_NICK: text = "NICK ";
      default:   text = "USER ";
    endcase
    return text[8 * (4 - int'(pos)) +: 8];
  endfunction

  // one byte through the handshake parser
  function automatic rhc_state_t step_handshake(input rhc_state_t st, input logic [7:0] b);
    rhc_state_t nx;
    logic       cr_before;
    nx = st;
    if (st.failed || st.complete) return nx;
    cr_before      = st.prev_was_cr;
    nx.prev_was_cr = (b == CH_CR);

    // greeting line must match exactly, CR LF included
    if (st.line_number == LINE_GREETING) begin
      if (b != GREETING[st.match_position[2:0]]) begin
        nx.failed = 1'b1;
      end else if (st.match_position >= GREETING_LAST) begin
        nx.line_number    = LINE_PASS;
        nx.match_position = '0;
        nx.prev_was_cr    = 1'b0;
      end else begin
        nx.match_position = st.match_position + 4'd1;
      end
      return nx;
    end
    if (st.line_number > LINE_USER) begin
      nx.failed = 1'b1;
      return nx;
    end

    // command word
    if (st.match_position < PREFIX_LEN) begin
      if (b != command_char(st.line_number, st.match_position)) nx.failed = 1'b1;
      else nx.match_position = st.match_position + 4'd1;
      return nx;
    end

    // user fields, then the colon
    if (st.line_number == LINE_USER && st.user_field_step < USER_BODY) begin
      if (st.user_field_step == USER_COLON) begin
        if (b != CH_COLON) begin
          nx.failed = 1'b1;
        end else begin
          nx.user_field_step = USER_BODY;
          nx.match_position  = PREFIX_LEN;
          nx.prev_was_cr     = 1'b0;
        end
      end else if (b == CH_NUL) begin
        nx.failed = 1'b1;
      end else if (b == CH_SP) begin
        if (!st.body_seen) begin
          nx.failed = 1'b1;
        end else begin
          nx.user_field_step = st.user_field_step + 3'd1;
          nx.body_seen       = 1'b0;
        end
      end else if (b == CH_LF && cr_before) begin
        nx.failed = 1'b1;
      end else begin
        nx.body_seen = 1'b1;
      end
      return nx;
    end

    // line body, closed by CR LF after at least one real byte
    if (b == CH_LF) begin
      if (cr_before && st.match_position >= BODY_SAT) begin
        if (st.line_number == LINE_USER) begin
          nx.complete    = 1'b1;
          nx.line_number = LINE_DONE;
        end else begin
          nx.line_number = st.line_number + 3'd1;
        end
        nx.match_position = '0;
        nx.prev_was_cr    = 1'b0;
      end else begin
        nx.failed = 1'b1;
      end
    end else if (b == CH_NUL) begin
      nx.failed = 1'b1;
    end else if (st.match_position < BODY_SAT) begin
      nx.match_position = st.match_position + 4'd1;
    end
    return nx;
  endfunction

  task report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    fail_count_o++;
  endtask

  // watch both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_state = '0;
      pending_verdicts.delete();
      pending_o = 0;
    end else begin
      // verdict leaving the block
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch($sformatf("verdict %0h with no message pending", m_axis_tdata));
        end else begin
          verdict_exp = pending_verdicts.pop_front();
          if (m_axis_tdata[0] !== verdict_exp)
            report_mismatch($sformatf("accepted %b, predicted %b", m_axis_tdata[0],
                                      verdict_exp));
          if (m_axis_tdata[7:1] !== 7'd0)
            report_mismatch($sformatf("padding bits %b not zero", m_axis_tdata[7:1]));
        end
      end
      // byte entering the block
      if (s_axis_tvalid && s_axis_tready) begin
        next_state = step_handshake(parse_state, s_axis_tdata);
        bytes_o++;
        if (s_axis_tlast) begin
          verdict_exp = next_state.complete && !next_state.failed;
          pending_verdicts.push_back(verdict_exp);
          messages_o++;
          if (verdict_exp) accepted_o++;
          parse_state = '0;
        end else begin
          parse_state = next_state;
        end
      end
      pending_o = pending_verdicts.size();
    end
  end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Testbench top for the registration handshake checker: stimulus, idling and verdict
`default_nettype none

module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import rhc_pkg::*;

  localparam int RANDOM_BYTES = 1900;
  localparam int STALL_LIMIT  = 3000;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;     // [7:0] data_byte
  logic       s_axis_tlast  = 1'b0;   // end_of_message
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [0] accepted, [7:1] zero

  int fail_count;
  int pending_count;
  int bytes_seen;
  int messages_seen;
  int accepted_seen;

  int         src_idle_pct = 12;
  int         dst_idle_pct = 84;
  int         stall_cycles = 0;
  int         random_bytes = 0;
  logic [7:0] message [$];

  registration_handshake_checker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rhc_verdict_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending_count),
    .bytes_o       (bytes_seen),
    .messages_o    (messages_seen),
    .accepted_o    (accepted_seen)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver stalls at random
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  // watchdog on cycles in which no item moves
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  task push_text(input string s);
    for (int i = 0; i < s.len(); i++) message.push_back(s[i]);
  endtask

  task push_crlf;
    message.push_back(CH_CR);
    message.push_back(CH_LF);
  endtask

  // byte that tends to hit a delimiter or a forbidden value
  function automatic logic [7:0] awkward_byte();
    case ($urandom_range(5))
      0:       return CH_NUL;
      1:       return CH_LF;
      2:       return CH_CR;
      3:       return CH_SP;
      4:       return CH_COLON;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // body or user-field content, legal for its place
  task push_content(input int n, input bit user_field);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      if (user_field && $urandom_range(19) == 0 && message[$] != CH_CR) begin
        b = CH_LF;
      end else if ($urandom_range(9) == 0) begin
        b = CH_CR;
      end else begin
        do b = 8'($urandom_range(1, 255));
        while (b == CH_LF || (user_field && b == CH_SP));
      end
      message.push_back(b);
    end
  endtask

  function automatic int content_len();
    return ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
  endfunction

  // complete registration with random content
  task build_well_formed;
    push_text("CAP LS");
    push_crlf();
    push_text("PASS ");
    push_content(content_len(), 1'b0);
    push_crlf();
    push_text("NICK ");
    push_content(content_len(), 1'b0);
    push_crlf();
    push_text("USER ");
    repeat (3) begin
      push_content(content_len(), 1'b1);
      message.push_back(CH_SP);
    end
    message.push_back(CH_COLON);
    push_content(content_len(), 1'b0);
    push_crlf();
    // trailing bytes after the user line are ignored
    if ($urandom_range(9) < 3)
      repeat ($urandom_range(1, 4)) message.push_back(awkward_byte());
  endtask

  // one random message: mostly well formed, some damaged, some noise
  task build_random;
    int pick;
    int idx;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 8)) message.push_back(8'($urandom_range(255)));
      return;
    end
    build_well_formed();
    if ($urandom_range(9) < 3) begin
      pick = $urandom_range(3);
      idx  = $urandom_range(message.size() - 1);
      case (pick)
        0: while (message.size() > idx + 1) void'(message.pop_back());
        1: message[idx] = ($urandom_range(1)) ? awkward_byte() : 8'($urandom_range(255));
        2: message.insert(idx, awkward_byte());
        default: message.delete(idx);
      endcase
    end
  endtask

  task send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task send_message;
    for (int i = 0; i < message.size(); i++) send_byte(message[i], i == message.size() - 1);
    message.delete();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // single-byte messages at both ends of the byte range
    message.push_back(8'h00);
    send_message();
    message.push_back(8'hFF);
    send_message();
    // shortest legal registration, then bytes past the user line
    push_text("CAP LS");
    push_crlf();
    push_text("PASS x");
    push_crlf();
    push_text("NICK y");
    push_crlf();
    push_text("USER a b c :d");
    push_crlf();
    message.push_back(8'h00);
    message.push_back(8'hFF);
    push_crlf();
    send_message();
    // password body of one lone CR is ordinary content
    push_text("CAP LS");
    push_crlf();
    push_text("PASS ");
    message.push_back(CH_CR);
    push_crlf();
    send_message();
    // message cut off inside the greeting
    push_text("CAP");
    send_message();

    // random messages under changing back pressure
    while (random_bytes < RANDOM_BYTES) begin
      if (random_bytes < RANDOM_BYTES / 3) begin
        src_idle_pct = 12;
        dst_idle_pct = 84;
      end else if (random_bytes < 2 * RANDOM_BYTES / 3) begin
        src_idle_pct = 84;
        dst_idle_pct = 12;
      end else begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
      build_random();
      random_bytes += message.size();
      send_message();
    end
    s_axis_tvalid <= 1'b0;

    // drain outstanding verdicts
    while (pending_count != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);

    $display("run covered %0d bytes in %0d messages, %0d of them judged well formed",
             bytes_seen, messages_seen, accepted_seen);
    $display("idling went from a slow receiver to a slow sender to none at all");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
